FILE: sv/apu_pkg.sv
// Package for the alpha premultiply / unpremultiply block.
// Holds the beat payload types, the divider pipeline types and the full-scale constants.
// No dependencies.
package apu_pkg;

   localparam int CHAN_W    = 16;
   localparam int REM_W     = CHAN_W - 1;
   localparam int NUM_LANES = 3;
   localparam int NUM_CELLS = CHAN_W;

   localparam logic [CHAN_W-1:0] FULL_NARROW = 16'd255;
   localparam logic [CHAN_W-1:0] FULL_DEEP   = 16'd32768;

   typedef enum logic {
      CSR_UNPREMULTIPLY_MODE = 1'b0,
      CSR_DEEP_CHANNELS      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha_in;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha_out;
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } rsp_type;

   // One colour lane of the divider: partial remainder and a word that
   // shifts dividend bits out at the top and quotient bits in at the bottom.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [CHAN_W-1:0] word;
   } lane_type;

   typedef struct packed {
      logic                 bypass;
      logic [NUM_LANES-1:0] sat;
      logic [CHAN_W-1:0]    full;
      logic [CHAN_W-1:0]    divisor;
      logic [CHAN_W-1:0]    alpha;
      lane_type [NUM_LANES-1:0] lane;
   } stage_type;

endpackage

FILE: sv/apu_prep.sv
// Entry stage: sets up dividend and divisor for each colour lane.
// Uses apu_pkg.
module apu_prep import apu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      beat_in,
   input  req_type   req_data,
   input  logic      mode_unpre,
   input  logic      mode_deep,
   output logic      valid_out,
   output stage_type stage_out
);

   logic              valid_ff, valid_in;
   stage_type         stage_ff, stage_in;
   logic [CHAN_W-1:0] full;
   logic [CHAN_W-1:0] alpha;
   logic [CHAN_W-1:0] mult;
   logic              is_zero, is_pass;
   logic [CHAN_W-1:0] colour [NUM_LANES];
   logic [2*CHAN_W-1:0] prod [NUM_LANES];
   logic [2*CHAN_W-2:0] dividend [NUM_LANES];

   assign alpha     = req_data.alpha_in;
   assign colour[0] = req_data.red_in;
   assign colour[1] = req_data.green_in;
   assign colour[2] = req_data.blue_in;

   always_comb begin
      full    = mode_deep ? FULL_DEEP : FULL_NARROW;
      is_zero = (alpha == '0);
      is_pass = (alpha >= full);
      mult    = mode_unpre ? full : alpha;

      stage_in.bypass = is_zero || is_pass;
      stage_in.full   = full;
      stage_in.alpha  = alpha;
      if (is_zero || is_pass) begin
         stage_in.divisor = CHAN_W'(1);
      end else if (mode_unpre) begin
         stage_in.divisor = alpha;
      end else begin
         stage_in.divisor = full;
      end

      for (int i = 0; i < NUM_LANES; i++) begin
         prod[i] = colour[i] * mult;
         // colour >= alpha means colour*full/alpha is at least full
         stage_in.sat[i] = mode_unpre && !is_zero && !is_pass && (colour[i] >= alpha);
         if (is_zero) begin
            dividend[i] = '0;
         end else if (is_pass) begin
            dividend[i] = (2*CHAN_W-1)'(colour[i]);
         end else begin
            dividend[i] = prod[i][2*CHAN_W-2:0];
         end
         stage_in.lane[i].rem  = dividend[i][2*CHAN_W-2:CHAN_W];
         stage_in.lane[i].word = dividend[i][CHAN_W-1:0];
      end
   end

   assign valid_in = beat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: sv/apu_cell.sv
// Divider cell: one restoring step per lane, yielding one quotient bit.
// Uses apu_pkg.
module apu_cell import apu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  stage_type stage_in,
   output logic      valid_out,
   output stage_type stage_out
);

   logic              valid_ff;
   stage_type         stage_ff, stage_nx;
   logic [CHAN_W-1:0] trial [NUM_LANES];
   logic [CHAN_W-1:0] diff  [NUM_LANES];
   logic              take  [NUM_LANES];

   always_comb begin
      stage_nx = stage_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         trial[i] = {stage_in.lane[i].rem, stage_in.lane[i].word[CHAN_W-1]};
         take[i]  = (trial[i] >= stage_in.divisor);
         diff[i]  = trial[i] - stage_in.divisor;
         stage_nx.lane[i].rem  = take[i] ? diff[i][REM_W-1:0] : trial[i][REM_W-1:0];
         stage_nx.lane[i].word = {stage_in.lane[i].word[CHAN_W-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: sv/alpha_premultiply_unpremultiply.sv
// Alpha premultiply / unpremultiply, top level.
// Uses apu_pkg, apu_prep and a row of apu_cell divider cells.
//
// Usage:
//   req_*  : one pixel (alpha, red, green, blue) per beat, valid/ready.
//   rsp_*  : one converted pixel per beat, valid/ready, in input order.
//   csr_*  : write-only registers; index 0 selects unpremultiply, index 1
//            selects 16-bit depth (full scale 32768 instead of 255). Write
//            them only while no pixel is in flight.
//   Throughput is one pixel per clock while the receiver does not stall. A pixel
//   accepted passes one setup stage, sixteen divider cells (one quotient bit
//   each) and the output register before it shows on rsp_valid.
//   Premultiply runs the same cells with the product as dividend and full
//   scale as divisor; unpremultiply divides colour*full by alpha.
//   When the receiver stalls, the output register holds its beat and one
//   more beat lands in a skid register; req_ready then drops and the whole
//   pipeline holds until the skid register drains.
//   Reset clears all valid bits and both mode registers; nothing is in flight.
module alpha_premultiply_unpremultiply import apu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write,
   input  logic    csr_index,
   input  logic    csr_wdata
);

   logic      mode_unpre_ff, mode_unpre_in;
   logic      mode_deep_ff, mode_deep_in;
   logic      advance;
   logic      chain_valid [NUM_CELLS+1];
   stage_type chain_stage [NUM_CELLS+1];
   stage_type last;
   rsp_type   result;
   logic [CHAN_W-1:0] quot [NUM_LANES];
   logic [CHAN_W-1:0] conv [NUM_LANES];
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      skid_valid_ff, skid_valid_in;
   rsp_type   skid_data_ff, skid_data_in;

   always_comb begin
      mode_unpre_in = mode_unpre_ff;
      mode_deep_in  = mode_deep_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_UNPREMULTIPLY_MODE: mode_unpre_in = csr_wdata;
            CSR_DEEP_CHANNELS:      mode_deep_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_unpre_ff <= 1'b0;
         mode_deep_ff  <= 1'b0;
      end else begin
         mode_unpre_ff <= mode_unpre_in;
         mode_deep_ff  <= mode_deep_in;
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   apu_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .beat_in    (req_valid && req_ready),
      .req_data   (req_data),
      .mode_unpre (mode_unpre_ff),
      .mode_deep  (mode_deep_ff),
      .valid_out  (chain_valid[0]),
      .stage_out  (chain_stage[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      apu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (chain_valid[k]),
         .stage_in  (chain_stage[k]),
         .valid_out (chain_valid[k+1]),
         .stage_out (chain_stage[k+1])
      );
   end

   assign last = chain_stage[NUM_CELLS];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         quot[i] = last.lane[i].word;
         if (last.sat[i] || (!last.bypass && (quot[i] > last.full))) begin
            conv[i] = last.full;
         end else begin
            conv[i] = quot[i];
         end
      end
      result.alpha_out = last.alpha;
      result.red_out   = conv[0];
      result.green_out = conv[1];
      result.blue_out  = conv[2];
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in = chain_valid[NUM_CELLS];
         rsp_data_in  = result;
      end else if (chain_valid[NUM_CELLS]) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
